// ===== rtl/tsjb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsjb_pkg: shared types and codes for the timestamp sorted jitter buffer
// Request codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package tsjb_pkg;

  localparam int SLOT_DEPTH = 64;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_TAKE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_CHAN   = 3'd2,
    ST_SIZE   = 3'd3,
    ST_NOSLOT = 3'd4,
    ST_EMPTY  = 3'd5,
    ST_BADREL = 3'd6
  } status_t;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_PAYLOAD  = 2'd1;
  localparam logic [1:0] CFG_MAXCH    = 2'd2;

  localparam logic [6:0]  CAPACITY_RST = 7'd64;
  localparam logic [15:0] PAYLOAD_RST  = 16'd4096;
  localparam logic [3:0]  MAXCH_RST    = 4'd2;

  // count above floor(capacity * 9 / 10) is the same as 10 * count > 9 * capacity
  function automatic logic over_nine_tenths(input logic [6:0] cnt,
                                            input logic [6:0] cap);
    logic [10:0] c10;
    logic [10:0] c9;
    c10 = {1'b0, cnt, 3'd0} + {3'd0, cnt, 1'b0};
    c9  = {1'b0, cap, 3'd0} + {4'd0, cap};
    return c10 > c9;
  endfunction

endpackage

// ===== rtl/tsjb_mult.sv =====
// ----------------------------------------------------------------------------
// tsjb_mult: frame size check
// Registered comparison of samples * channels * 2 against the payload size.
// ----------------------------------------------------------------------------
module tsjb_mult (
  input  logic        clk,
  input  logic [15:0] samples,
  input  logic [7:0]  chans,
  input  logic [15:0] limit,
  output logic        oversize_r
);
  logic [23:0] sc;
  logic [24:0] prod;
  assign sc   = 24'(samples) * 24'(chans);
  assign prod = {sc, 1'b0};
  always_ff @(posedge clk) begin
    oversize_r <= prod > {9'd0, limit};
  end
endmodule

// ===== rtl/timestamp_sorted_jitter_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamp_sorted_jitter_buffer: timestamp ordered reorder buffer
// Sequencer over order/slot memories with one shared timestamp comparator.
// ----------------------------------------------------------------------------
// Insert: checks, evicts the head while at capacity, allocates a slot, searches the
// position in K <= ceil(log2(N+1)) search steps (N queued), then shifts the tail up;
// take shifts the list down, flush returns every queued slot to the free stack.
// Throughput: one word at a time; in_ready is low while a word is at work.
// The shared comparator and the single port order memory set the pace.
// Reset: synchronous active low; the free stack is rebuilt by a pass over all
// SLOT_DEPTH slots after reset, during which no word is accepted.
module timestamp_sorted_jitter_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_frame_timestamp,
  input  logic [15:0] in_sample_count,
  input  logic [7:0]  in_channel_count,
  input  logic [5:0]  in_release_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic [31:0] out_taken_timestamp,
  output logic [15:0] out_taken_samples,
  output logic [3:0]  out_taken_channels,
  output logic [6:0]  out_evicted_count,
  output logic [6:0]  out_frame_count,
  output logic        out_nearly_full,
  output logic        out_oldest_valid,
  output logic [31:0] out_oldest_timestamp,
  output logic [31:0] out_underrun_total,
  output logic [31:0] out_accepted_total
);
  localparam int SLOT_DEPTH = tsjb_pkg::SLOT_DEPTH;
  localparam int AW = $clog2(SLOT_DEPTH);
  localparam int CW = $clog2(SLOT_DEPTH + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_EVCHK, S_EVSH_RD, S_EVSH_WR, S_ALLOC,
    S_BS_RD, S_BS_TS, S_BS_CMP, S_SH_RD, S_SH_WR, S_FL_RD, S_FL_WR, S_FIN,
    S_PUB
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0]  cap_r;
  logic [15:0] payload_r;
  logic [3:0]  maxch_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= tsjb_pkg::CAPACITY_RST;
      payload_r <= tsjb_pkg::PAYLOAD_RST;
      maxch_r   <= tsjb_pkg::MAXCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsjb_pkg::CFG_CAPACITY: cap_r     <= cfg_data[6:0];
        tsjb_pkg::CFG_PAYLOAD:  payload_r <= cfg_data;
        tsjb_pkg::CFG_MAXCH:    maxch_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // memories: ordered list, free stack, slot records
  logic [AW-1:0] order_mem [SLOT_DEPTH];
  logic [AW-1:0] free_mem  [SLOT_DEPTH];
  logic [51:0]   slot_mem  [SLOT_DEPTH];  // {channels, samples, timestamp}

  // latched request
  logic [1:0]  req_r;
  logic [31:0] ts_r;
  logic [15:0] smp_r;
  logic [7:0]  ch_r;
  logic [5:0]  rel_r;

  logic [CW-1:0] qcnt_r, ftop_r, idx_r, lo_r, hi_r;
  logic [AW-1:0] slot_r, order_q_r;
  logic [51:0]   slot_q_r;
  logic [31:0]   under_r, acc_r, head_ts_r;
  logic [2:0]    st_r;
  logic [6:0]    evict_r;
  logic [5:0]    oslot_r;
  logic [51:0]   taken_r;
  logic          oversize_r;

  // size check registers the accepted word's oversize flag, ready in S_CHECK
  tsjb_mult u_mult (
    .clk(clk), .samples(in_sample_count), .chans(in_channel_count),
    .limit(payload_r), .oversize_r(oversize_r)
  );

  // shared comparator: entry timestamp before new timestamp
  logic [31:0] ts_diff;
  assign ts_diff = slot_q_r[31:0] - ts_r;

  logic [CW-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  logic [CW-1:0] cap_w;
  assign cap_w = CW'(cap_r);

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      idx_r     <= '0;
      qcnt_r    <= '0;
      ftop_r    <= CW'(SLOT_DEPTH);
      under_r   <= '0;
      acc_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          free_mem[idx_r[AW-1:0]] <= idx_r[AW-1:0];
          idx_r <= idx_r + 1'b1;
          if (idx_r == CW'(SLOT_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          req_r <= in_req_type; ts_r <= in_frame_timestamp;
          smp_r <= in_sample_count; ch_r <= in_channel_count;
          rel_r <= in_release_slot;
          st_r <= tsjb_pkg::ST_OK; evict_r <= '0; oslot_r <= '0; taken_r <= '0;
          idx_r <= '0;
          order_q_r <= order_mem[0];
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          unique case (tsjb_pkg::req_t'(req_r))
            tsjb_pkg::REQ_INSERT: begin
              if (smp_r == 16'd0) begin
                st_r <= tsjb_pkg::ST_ZERO; state_r <= S_FIN;
              end else if (ch_r == 8'd0 || ch_r > {4'd0, maxch_r}) begin
                st_r <= tsjb_pkg::ST_CHAN; state_r <= S_FIN;
              end else if (oversize_r) begin
                st_r <= tsjb_pkg::ST_SIZE; state_r <= S_FIN;
              end else state_r <= S_EVCHK;
            end
            tsjb_pkg::REQ_TAKE: begin
              if (qcnt_r == '0) begin
                st_r <= tsjb_pkg::ST_EMPTY; state_r <= S_FIN;
              end else begin
                oslot_r <= 6'(order_q_r);
                slot_q_r <= slot_mem[order_q_r];
                idx_r <= CW'(1);
                state_r <= S_EVSH_RD;
              end
            end
            tsjb_pkg::REQ_RELEASE: begin
              if ({26'd0, rel_r} >= 32'(SLOT_DEPTH) || ftop_r >= CW'(SLOT_DEPTH))
                st_r <= tsjb_pkg::ST_BADREL;
              else begin
                free_mem[ftop_r[AW-1:0]] <= AW'(rel_r);
                ftop_r <= ftop_r + 1'b1;
              end
              state_r <= S_FIN;
            end
            default: state_r <= S_FL_RD;
          endcase
        end
        S_EVCHK: begin
          order_q_r <= order_mem[0];
          if (qcnt_r >= cap_w && qcnt_r != '0) begin
            idx_r <= CW'(1);
            state_r <= S_EVSH_RD;
          end else state_r <= S_ALLOC;
        end
        // pop head: shift entries down, then push or report
        S_EVSH_RD: begin
          if (idx_r == CW'(1) && req_r == tsjb_pkg::REQ_TAKE)
            taken_r <= slot_q_r;
          if (idx_r < qcnt_r) begin
            slot_r <= order_mem[idx_r[AW-1:0]];
            state_r <= S_EVSH_WR;
          end else begin
            qcnt_r <= qcnt_r - 1'b1;
            if (req_r == tsjb_pkg::REQ_TAKE) state_r <= S_FIN;
            else begin
              evict_r <= evict_r + 1'b1;
              if (ftop_r < CW'(SLOT_DEPTH)) begin
                free_mem[ftop_r[AW-1:0]] <= order_q_r;
                ftop_r <= ftop_r + 1'b1;
              end
              state_r <= S_EVCHK;
            end
          end
        end
        S_EVSH_WR: begin
          order_mem[idx_r[AW-1:0] - 1'b1] <= slot_r;
          idx_r <= idx_r + 1'b1;
          state_r <= S_EVSH_RD;
        end
        S_ALLOC: begin
          if (ftop_r == '0) begin
            st_r <= tsjb_pkg::ST_NOSLOT;
            under_r <= under_r + 1'b1;
            state_r <= S_FIN;
          end else begin
            ftop_r <= ftop_r - 1'b1;
            slot_r <= free_mem[ftop_r[AW-1:0] - 1'b1];
            lo_r <= '0; hi_r <= qcnt_r;
            state_r <= S_BS_RD;
          end
        end
        S_BS_RD: begin
          slot_mem[slot_r] <= {ch_r[3:0], smp_r, ts_r};
          oslot_r <= 6'(slot_r);
          if (lo_r < hi_r) begin
            order_q_r <= order_mem[mid[AW-1:0]];
            state_r <= S_BS_TS;
          end else if (qcnt_r == CW'(SLOT_DEPTH)) begin
            // list already full (duplicate slot from a release): no placement
            acc_r <= acc_r + 1'b1;
            state_r <= S_FIN;
          end else begin
            idx_r <= qcnt_r;
            state_r <= S_SH_RD;
          end
        end
        S_BS_TS: begin
          slot_q_r <= slot_mem[order_q_r];
          state_r <= S_BS_CMP;
        end
        S_BS_CMP: begin
          if (ts_diff[31]) lo_r <= mid + 1'b1;
          else hi_r <= mid;
          state_r <= S_BS_RD;
        end
        // open a gap at lo, moving tail entries up one
        S_SH_RD: begin
          if (idx_r > lo_r) begin
            order_q_r <= order_mem[idx_r[AW-1:0] - 1'b1];
            state_r <= S_SH_WR;
          end else begin
            order_mem[lo_r[AW-1:0]] <= slot_r;
            qcnt_r <= qcnt_r + 1'b1;
            acc_r <= acc_r + 1'b1;
            state_r <= S_FIN;
          end
        end
        S_SH_WR: begin
          order_mem[idx_r[AW-1:0]] <= order_q_r;
          idx_r <= idx_r - 1'b1;
          state_r <= S_SH_RD;
        end
        S_FL_RD: begin
          if (idx_r < qcnt_r) begin
            order_q_r <= order_mem[idx_r[AW-1:0]];
            state_r <= S_FL_WR;
          end else begin
            qcnt_r <= '0;
            state_r <= S_FIN;
          end
        end
        S_FL_WR: begin
          if (ftop_r < CW'(SLOT_DEPTH)) begin
            free_mem[ftop_r[AW-1:0]] <= order_q_r;
            ftop_r <= ftop_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          state_r <= S_FL_RD;
        end
        S_FIN: begin // fetch head slot
          order_q_r <= order_mem[0];
          state_r <= S_PUB;
        end
        default: begin // S_PUB: read head timestamp, publish result word
          head_ts_r <= slot_mem[order_q_r][31:0];
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_status           = st_r;
  assign out_slot_index       = oslot_r;
  assign out_taken_timestamp  = taken_r[31:0];
  assign out_taken_samples    = taken_r[47:32];
  assign out_taken_channels   = taken_r[51:48];
  assign out_evicted_count    = evict_r;
  assign out_frame_count      = 7'(qcnt_r);
  assign out_nearly_full      = tsjb_pkg::over_nine_tenths(7'(qcnt_r), cap_r);
  assign out_oldest_valid     = qcnt_r != '0;
  assign out_oldest_timestamp = (qcnt_r != '0) ? head_ts_r : 32'd0;
  assign out_underrun_total   = under_r;
  assign out_accepted_total   = acc_r;
endmodule

// ===== rtl/tsjb_checker.sv =====
// ----------------------------------------------------------------------------
// tsjb_checker: port level checks for the jitter buffer
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
module tsjb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [6:0]  out_frame_count,
  input logic        out_oldest_valid,
  input logic [31:0] out_oldest_timestamp
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_oldv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_oldest_valid == (out_frame_count != 7'd0))
    else $error("oldest flag mismatch");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_oldest_valid |-> out_oldest_timestamp == 32'd0)
    else $error("stale head timestamp");
endmodule

bind timestamp_sorted_jitter_buffer tsjb_checker u_tsjb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_frame_count(out_frame_count), .out_oldest_valid(out_oldest_valid),
  .out_oldest_timestamp(out_oldest_timestamp)
);

// ===== tb/tb_timestamp_sorted_jitter_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_timestamp_sorted_jitter_buffer: self-checking bench for the jitter buffer
// Drives insert, take, release and flush words under several register
// settings and idle patterns, predicts every result word and compares it.
// ----------------------------------------------------------------------------
module tb_timestamp_sorted_jitter_buffer;

  localparam int DEPTH = 64;

  // one result word, as the block presents it
  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] taken_ts;
    logic [15:0] taken_smp;
    logic [3:0]  taken_ch;
    logic [6:0]  evicted;
    logic [6:0]  frames;
    logic        nearly_full;
    logic        oldest_valid;
    logic [31:0] oldest_ts;
    logic [31:0] underruns;
    logic [31:0] accepted;
  } result_t;

  // Scoreboard: a model of the reorder buffer plus the queue of
  // expected result words.
  class jitter_scoreboard;
    logic [6:0]  capacity;
    logic [15:0] payload_bytes;
    logic [3:0]  max_ch;
    logic [5:0]  order_q[DEPTH];
    logic [5:0]  spare_slots[DEPTH];
    int          spare_cnt;
    int          queued;
    logic [31:0] slot_ts[DEPTH];
    logic [15:0] slot_smp[DEPTH];
    logic [3:0]  slot_ch[DEPTH];
    logic [31:0] underruns;
    logic [31:0] accepted;
    result_t     expected_q[$];
    logic [5:0]  taken_slots[$];
    int          errors;
    int          checked;
    int          n_noslot, n_evict, n_take;

    function new();
      capacity = tsjb_pkg::CAPACITY_RST;
      payload_bytes = tsjb_pkg::PAYLOAD_RST;
      max_ch = tsjb_pkg::MAXCH_RST;
      for (int i = 0; i < DEPTH; i++) begin
        spare_slots[i] = 6'(i);
        order_q[i] = '0;
        slot_ts[i] = '0;
        slot_smp[i] = '0;
        slot_ch[i] = '0;
      end
      spare_cnt = DEPTH;
      queued = 0;
      underruns = '0;
      accepted = '0;
      errors = 0;
      checked = 0;
      n_noslot = 0;
      n_evict = 0;
      n_take = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tsjb_pkg::CFG_CAPACITY: capacity = val[6:0];
        tsjb_pkg::CFG_PAYLOAD:  payload_bytes = val;
        tsjb_pkg::CFG_MAXCH:    max_ch = val[3:0];
        default: ;
      endcase
    endfunction

    // wraparound compare: a before b when a - b is negative
    function bit ts_earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function void push_free(logic [5:0] s);
      if (spare_cnt < DEPTH) begin
        spare_slots[spare_cnt] = s;
        spare_cnt++;
      end
    endfunction

    function logic [5:0] pop_oldest();
      logic [5:0] h;
      h = order_q[0];
      for (int i = 1; i < queued; i++) order_q[i-1] = order_q[i];
      queued--;
      return h;
    endfunction

    // accepted input word: advance the model, queue the expected result
    function void note_input(tsjb_pkg::req_t req, logic [31:0] ts, logic [15:0] smp,
                             logic [7:0] ch, logic [5:0] rel);
      result_t r;
      logic [5:0] s;
      int lo, hi, mid;
      r = '{default: '0};
      r.status = tsjb_pkg::ST_OK;
      case (req)
        tsjb_pkg::REQ_INSERT: begin
          if (smp == 0) r.status = tsjb_pkg::ST_ZERO;
          else if (ch < 1 || ch > {4'd0, max_ch}) r.status = tsjb_pkg::ST_CHAN;
          else if (32'(smp) * 32'(ch) * 2 > 32'(payload_bytes))
            r.status = tsjb_pkg::ST_SIZE;
          else begin
            while (queued >= int'(capacity) && queued > 0) begin
              push_free(pop_oldest());
              r.evicted++;
            end
            if (r.evicted != 0) n_evict++;
            if (spare_cnt == 0) begin
              r.status = tsjb_pkg::ST_NOSLOT;
              underruns++;
              n_noslot++;
            end else begin
              spare_cnt--;
              s = spare_slots[spare_cnt];
              slot_ts[s] = ts;
              slot_smp[s] = smp;
              slot_ch[s] = ch[3:0];
              lo = 0;
              hi = queued;
              while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (ts_earlier(slot_ts[order_q[mid]], ts)) lo = mid + 1;
                else hi = mid;
              end
              if (queued < DEPTH) begin
                for (int i = queued; i > lo; i--) order_q[i] = order_q[i-1];
                order_q[lo] = s;
                queued++;
              end
              accepted++;
              r.slot_index = s;
            end
          end
        end
        tsjb_pkg::REQ_TAKE: begin
          if (queued == 0) r.status = tsjb_pkg::ST_EMPTY;
          else begin
            s = pop_oldest();
            r.slot_index = s;
            r.taken_ts = slot_ts[s];
            r.taken_smp = slot_smp[s];
            r.taken_ch = slot_ch[s];
            taken_slots.push_back(s);
            n_take++;
          end
        end
        tsjb_pkg::REQ_RELEASE: begin
          if (spare_cnt >= DEPTH) r.status = tsjb_pkg::ST_BADREL;
          else push_free(rel);
        end
        default: begin
          for (int i = 0; i < queued; i++) push_free(order_q[i]);
          queued = 0;
        end
      endcase
      r.frames = 7'(queued);
      r.nearly_full = (queued > (int'(capacity) * 9) / 10);
      r.oldest_valid = (queued > 0);
      r.oldest_ts = (queued > 0) ? slot_ts[order_q[0]] : '0;
      r.underruns = underruns;
      r.accepted = accepted;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch #%0d word %0d %s: got %0h want %0h",
                 errors, checked, what, got, want);
    endtask

    task check_result(result_t got);
      result_t w;
      if (expected_q.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      w = expected_q.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.slot_index !== w.slot_index)
        report("slot_index", got.slot_index, w.slot_index);
      if (got.taken_ts !== w.taken_ts)
        report("taken_timestamp", got.taken_ts, w.taken_ts);
      if (got.taken_smp !== w.taken_smp)
        report("taken_samples", got.taken_smp, w.taken_smp);
      if (got.taken_ch !== w.taken_ch)
        report("taken_channels", got.taken_ch, w.taken_ch);
      if (got.evicted !== w.evicted) report("evicted_count", got.evicted, w.evicted);
      if (got.frames !== w.frames) report("frame_count", got.frames, w.frames);
      if (got.nearly_full !== w.nearly_full)
        report("nearly_full", got.nearly_full, w.nearly_full);
      if (got.oldest_valid !== w.oldest_valid)
        report("oldest_valid", got.oldest_valid, w.oldest_valid);
      if (got.oldest_ts !== w.oldest_ts)
        report("oldest_timestamp", got.oldest_ts, w.oldest_ts);
      if (got.underruns !== w.underruns)
        report("underrun_total", got.underruns, w.underruns);
      if (got.accepted !== w.accepted)
        report("accepted_total", got.accepted, w.accepted);
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_frame_timestamp = '0;
  logic [15:0] in_sample_count = '0;
  logic [7:0]  in_channel_count = '0;
  logic [5:0]  in_release_slot = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     res;

  timestamp_sorted_jitter_buffer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_frame_timestamp(in_frame_timestamp),
    .in_sample_count(in_sample_count), .in_channel_count(in_channel_count),
    .in_release_slot(in_release_slot),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(res.status), .out_slot_index(res.slot_index),
    .out_taken_timestamp(res.taken_ts), .out_taken_samples(res.taken_smp),
    .out_taken_channels(res.taken_ch), .out_evicted_count(res.evicted),
    .out_frame_count(res.frames), .out_nearly_full(res.nearly_full),
    .out_oldest_valid(res.oldest_valid), .out_oldest_timestamp(res.oldest_ts),
    .out_underrun_total(res.underruns), .out_accepted_total(res.accepted)
  );

  always #5 clk = ~clk;

  jitter_scoreboard sb = new();

  // idle pattern knobs, changed per phase by the main sequence
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;     // long receiver hold-off for backpressure
  logic [31:0] ts_base = 32'hFFFF_F000;  // walks across the 32-bit wrap
  logic [31:0] last_ts = '0;

  // receiver: checks each accepted result word, stalls at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(res);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input word; valid drops only when an idle gap follows
  task automatic send_word(tsjb_pkg::req_t req, logic [31:0] ts, logic [15:0] smp,
                           logic [7:0] ch, logic [5:0] rel);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_frame_timestamp <= ts;
    in_sample_count <= smp;
    in_channel_count <= ch;
    in_release_slot <= rel;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req, ts, smp, ch, rel);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // all expected words in, then a short settle before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random word, mostly well-formed traffic with jittered timestamps
  task automatic random_word();
    int r, ch, lim;
    logic [31:0] ts;
    r = $urandom_range(99);
    if (r < 50) begin
      if ($urandom_range(99) < 85) begin
        ch = $urandom_range(1, (sb.max_ch == 0) ? 1 : sb.max_ch);
        lim = sb.payload_bytes / (2 * ch);
        if (lim < 1) lim = 1;
        if (lim > 65535) lim = 65535;
        ts_base += 160;
        case ($urandom_range(3))
          0: ts = last_ts;                       // duplicate timestamp
          1: ts = ts_base;
          default: ts = ts_base + $urandom_range(0, 2000) - 1000;
        endcase
        last_ts = ts;
        send_word(tsjb_pkg::REQ_INSERT, ts, 16'($urandom_range(1, lim)), 8'(ch),
                  6'($urandom));
      end else begin
        send_word(tsjb_pkg::REQ_INSERT, $urandom, 16'($urandom), 8'($urandom),
                  6'($urandom));
      end
    end else if (r < 75) begin
      send_word(tsjb_pkg::REQ_TAKE, $urandom, 16'($urandom), 8'($urandom), 6'($urandom));
    end else if (r < 96) begin
      if (sb.taken_slots.size() != 0 && $urandom_range(99) < 85) begin
        lim = $urandom_range(sb.taken_slots.size() - 1);
        send_word(tsjb_pkg::REQ_RELEASE, $urandom, 16'($urandom), 8'($urandom),
                  sb.taken_slots[lim]);
        sb.taken_slots.delete(lim);
      end else begin
        send_word(tsjb_pkg::REQ_RELEASE, $urandom, 16'($urandom), 8'($urandom),
                  6'($urandom));
      end
    end else begin
      send_word(tsjb_pkg::REQ_FLUSH, $urandom, 16'($urandom), 8'($urandom), 6'($urandom));
      sb.taken_slots.delete();
    end
  endtask

  task automatic set_regs(logic [6:0] cap, logic [15:0] pay, logic [3:0] mc);
    write_reg(tsjb_pkg::CFG_CAPACITY, {9'd0, cap});
    write_reg(tsjb_pkg::CFG_PAYLOAD, pay);
    write_reg(tsjb_pkg::CFG_MAXCH, {12'd0, mc});
  endtask

  task automatic set_idle(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, field extremes and the special cases
    send_word(tsjb_pkg::REQ_RELEASE, 32'd0, 16'd0, 8'd0, 6'd63);        // stack full
    send_word(tsjb_pkg::REQ_TAKE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 6'd0); // empty take
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd0, 8'd1, 6'd0);         // zero samples
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd1, 8'd0, 6'd0);         // no channels
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd1, 8'd255, 6'd0);       // too many
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd1, 8'd3, 6'd0);
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'hFFFF, 8'd2, 6'd0);      // oversize
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd1025, 8'd2, 6'd0);      // one over
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd1024, 8'd2, 6'd0);      // exactly fits
    send_word(tsjb_pkg::REQ_INSERT, 32'hFFFF_FFF0, 16'd1, 8'd1, 6'd0);   // wraps before
    send_word(tsjb_pkg::REQ_INSERT, 32'd100, 16'd7, 8'd1, 6'd0);         // equal stamp
    send_word(tsjb_pkg::REQ_INSERT, 32'h8000_0064, 16'd9, 8'd2, 6'd0);   // half range
    send_word(tsjb_pkg::REQ_INSERT, 32'd0, 16'd2048, 8'd1, 6'd0);
    send_word(tsjb_pkg::REQ_TAKE, 32'd0, 16'd0, 8'd0, 6'd0);
    send_word(tsjb_pkg::REQ_TAKE, 32'd0, 16'd0, 8'd0, 6'd0);
    send_word(tsjb_pkg::REQ_RELEASE, 32'd0, 16'd0, 8'd0, sb.taken_slots.pop_front());
    send_word(tsjb_pkg::REQ_FLUSH, 32'd0, 16'd0, 8'd0, 6'd0);
    send_word(tsjb_pkg::REQ_RELEASE, 32'd0, 16'd0, 8'd0, sb.taken_slots.pop_front());
    send_word(tsjb_pkg::REQ_TAKE, 32'd0, 16'd0, 8'd0, 6'd0);             // empty again
    drain();

    // capacity one: each accepted insert after the first evicts the single queued frame
    set_regs(7'd1, 16'd100, 4'd1);
    for (int i = 0; i < 6; i++)
      send_word(tsjb_pkg::REQ_INSERT, 32'(i * 50), 16'd50, 8'd1, 6'd0);
    send_word(tsjb_pkg::REQ_INSERT, 32'd0, 16'd51, 8'd1, 6'd0);          // oversize
    drain();

    // random phases over several register settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(7'd64, 16'd4096, 4'd2);
        1: set_regs(7'd127, 16'hFFFF, 4'd15);   // bounded by free slots only
        2: set_regs(7'd8, 16'd2000, 4'd4);
        3: set_regs(7'd1, 16'd0, 4'd1);          // every otherwise valid insert oversize
        4: set_regs(7'd40, 16'd30000, 4'd7);
        5: set_regs(7'd64, 16'hFFFF, 4'd15);
        6: set_regs(7'd20, 16'd512, 4'd8);
        default: set_regs(7'd100, 16'h5555, 4'd10);
      endcase
      set_idle(ph);
      for (int n = 0; n < ((ph == 3) ? 60 : 180); n++) begin
        if (ph == 5 && n == 20) hold_cycles = 4000;  // fill up and stall input
        random_word();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("checked %0d result words: %0d takes, %0d inserts with eviction,",
             sb.checked, sb.n_take, sb.n_evict);
    $display("%0d refused for no free slot, over 10 register settings",
             sb.n_noslot);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tsjb_pkg.sv
rtl/tsjb_mult.sv
rtl/timestamp_sorted_jitter_buffer.sv
rtl/tsjb_checker.sv
tb/tb_timestamp_sorted_jitter_buffer.sv
